// ===== sv/saes_pkg.sv =====
// Shared types, constants and S-AES round functions for the CTR cipher block.
// No dependencies; imported by every module of the block.
`default_nettype none

package saes_pkg;

    localparam int BLOCK_W = 16;
    localparam int MODE_W  = 2;
    localparam int INDEX_W = 2;

    localparam logic [MODE_W-1:0] MODE_CTR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ENC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DEC = 2'd2;

    localparam logic [INDEX_W-1:0] REG_CIPHER_KEY    = 2'd0;
    localparam logic [INDEX_W-1:0] REG_COUNTER_START = 2'd1;
    localparam logic [INDEX_W-1:0] REG_CIPHER_MODE   = 2'd2;

    localparam logic [BLOCK_W-1:0] KEY_RESET     = 16'd0;
    localparam logic [BLOCK_W-1:0] COUNTER_RESET = 16'd1200;

    localparam logic [7:0] RCON_1 = 8'h80;
    localparam logic [7:0] RCON_2 = 8'h30;

    typedef logic [2:0][BLOCK_W-1:0] round_keys_t;

    typedef struct packed {
        logic                wen;
        logic [INDEX_W-1:0]  index;
        logic [BLOCK_W-1:0]  data;
    } cfg_write_t;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [BLOCK_W-1:0]  counter_used;
        logic [BLOCK_W-1:0]  data_block;
    } item_t;

    function automatic logic [3:0] sbox_fwd(input logic [3:0] n);
        logic [3:0] r;
        unique case (n)
            4'h0: r = 4'h9;
            4'h1: r = 4'h4;
            4'h2: r = 4'hA;
            4'h3: r = 4'hB;
            4'h4: r = 4'hD;
            4'h5: r = 4'h1;
            4'h6: r = 4'h8;
            4'h7: r = 4'h5;
            4'h8: r = 4'h6;
            4'h9: r = 4'h2;
            4'hA: r = 4'h0;
            4'hB: r = 4'h3;
            4'hC: r = 4'hC;
            4'hD: r = 4'hE;
            4'hE: r = 4'hF;
            default: r = 4'h7;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] sbox_inv(input logic [3:0] n);
        logic [3:0] r;
        unique case (n)
            4'h0: r = 4'hA;
            4'h1: r = 4'h5;
            4'h2: r = 4'h9;
            4'h3: r = 4'hB;
            4'h4: r = 4'h1;
            4'h5: r = 4'h7;
            4'h6: r = 4'h8;
            4'h7: r = 4'hF;
            4'h8: r = 4'h6;
            4'h9: r = 4'h0;
            4'hA: r = 4'h2;
            4'hB: r = 4'h3;
            4'hC: r = 4'hC;
            4'hD: r = 4'h4;
            4'hE: r = 4'hD;
            default: r = 4'hE;
        endcase
        return r;
    endfunction

    // GF(16) multiply, modulus x^4 + x + 1
    function automatic logic [3:0] gf_mul(input logic [3:0] a, input logic [3:0] b);
        logic [3:0] p;
        logic [3:0] x;
        p = 4'h0;
        x = a;
        for (int i = 0; i < 4; i++) begin
            if (b[i])
            begin
                p = p ^ x;
            end
            x = {x[2:0], 1'b0} ^ (x[3] ? 4'h3 : 4'h0);
        end
        return p;
    endfunction

    function automatic logic [15:0] sub_fwd(input logic [15:0] s);
        return {sbox_fwd(s[15:12]), sbox_fwd(s[11:8]), sbox_fwd(s[7:4]), sbox_fwd(s[3:0])};
    endfunction

    function automatic logic [15:0] sub_inv(input logic [15:0] s);
        return {sbox_inv(s[15:12]), sbox_inv(s[11:8]), sbox_inv(s[7:4]), sbox_inv(s[3:0])};
    endfunction

    function automatic logic [15:0] shift_rows(input logic [15:0] s);
        return {s[15:12], s[3:0], s[7:4], s[11:8]};
    endfunction

    function automatic logic [15:0] mix_cols(input logic [15:0] s, input logic [3:0] diag,
                                             input logic [3:0] off);
        logic [3:0] m0, m1, m2, m3;
        m0 = gf_mul(diag, s[15:12]) ^ gf_mul(off, s[11:8]);
        m1 = gf_mul(off, s[15:12]) ^ gf_mul(diag, s[11:8]);
        m2 = gf_mul(diag, s[7:4]) ^ gf_mul(off, s[3:0]);
        m3 = gf_mul(off, s[7:4]) ^ gf_mul(diag, s[3:0]);
        return {m0, m1, m2, m3};
    endfunction

    function automatic logic [7:0] g_word(input logic [7:0] w, input logic [7:0] rcon);
        return {sbox_fwd(w[3:0]), sbox_fwd(w[7:4])} ^ rcon;
    endfunction

    function automatic round_keys_t expand_key(input logic [15:0] key);
        logic [7:0] w0, w1, w2, w3, w4, w5;
        round_keys_t k;
        w0 = key[15:8];
        w1 = key[7:0];
        w2 = w0 ^ g_word(w1, RCON_1);
        w3 = w2 ^ w1;
        w4 = w2 ^ g_word(w3, RCON_2);
        w5 = w4 ^ w3;
        k[0] = {w0, w1};
        k[1] = {w2, w3};
        k[2] = {w4, w5};
        return k;
    endfunction

    function automatic logic [15:0] encrypt_block(input logic [15:0] b, input round_keys_t k);
        logic [15:0] s;
        s = b ^ k[0];
        s = mix_cols(shift_rows(sub_fwd(s)), 4'h1, 4'h4) ^ k[1];
        s = shift_rows(sub_fwd(s)) ^ k[2];
        return s;
    endfunction

    function automatic logic [15:0] decrypt_block(input logic [15:0] b, input round_keys_t k);
        logic [15:0] s;
        s = b ^ k[2];
        s = sub_inv(shift_rows(s)) ^ k[1];
        s = mix_cols(s, 4'h9, 4'h2);
        s = sub_inv(shift_rows(s)) ^ k[0];
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== sv/saes_front.sv =====
// Front end: accepts input items, tags them with mode and counter value.
// Holds the running counter and mode register. Depends on saes_pkg.
`default_nettype none

module saes_front
    import saes_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire cfg_write_t   cfg,
    input  wire logic         push,
    input  wire logic [15:0]  data_block,
    input  wire logic         queue_full,
    output logic              queue_push,
    output item_t             queue_item
);

    logic [MODE_W-1:0]  mode_reg;
    logic [MODE_W-1:0]  mode_next;
    logic [BLOCK_W-1:0] counter_reg;
    logic [BLOCK_W-1:0] counter_next;
    logic               accept;

    assign accept     = push && !queue_full;
    assign queue_push = accept;

    always_comb
    begin
        queue_item.mode         = mode_reg;
        queue_item.data_block   = data_block;
        queue_item.counter_used = (mode_reg == MODE_CTR) ? counter_reg : '0;
    end

    always_comb
    begin
        mode_next    = mode_reg;
        counter_next = counter_reg;
        if (cfg.wen && cfg.index == REG_CIPHER_MODE)
        begin
            mode_next = cfg.data[MODE_W-1:0];
        end
        if (cfg.wen && cfg.index == REG_COUNTER_START)
        begin
            counter_next = cfg.data;
        end
        else if (accept && mode_reg == MODE_CTR)
        begin
            counter_next = counter_reg + 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_CTR;
            counter_reg <= COUNTER_RESET;
        end
        else
        begin
            mode_reg    <= mode_next;
            counter_reg <= counter_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/saes_queue.sv =====
// Small register queue of tagged items between front and back end.
// Depends on saes_pkg for the item type.
`default_nettype none

module saes_queue
    import saes_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire item_t  push_item,
    output logic        full,
    input  wire logic   pop,
    output item_t       head,
    output logic        empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    item_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == FULL_COUNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== sv/saes_back.sv =====
// Back end: holds the round keys, runs the two S-AES rounds and the output register.
// Depends on saes_pkg for types and round functions.
`default_nettype none

module saes_back
    import saes_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire cfg_write_t   cfg,
    input  wire item_t        head,
    input  wire logic         queue_empty,
    output logic              queue_pop,
    output logic              empty,
    input  wire logic         pop,
    output logic [15:0]       result_block,
    output logic [15:0]       counter_used
);

    round_keys_t        keys_reg;
    round_keys_t        keys_next;
    logic               valid_reg;
    logic               valid_next;
    logic [BLOCK_W-1:0] result_reg;
    logic [BLOCK_W-1:0] result_next;
    logic [BLOCK_W-1:0] counter_used_reg;
    logic               take;

    assign take      = !queue_empty && (!valid_reg || pop);
    assign queue_pop = take;
    assign empty        = !valid_reg;
    assign result_block = result_reg;
    assign counter_used = counter_used_reg;

    always_comb
    begin
        keys_next = keys_reg;
        if (cfg.wen && cfg.index == REG_CIPHER_KEY)
        begin
            keys_next = expand_key(cfg.data);
        end
    end

    always_comb
    begin
        unique case (head.mode)
            MODE_CTR: result_next = head.data_block ^ encrypt_block(head.counter_used, keys_reg);
            MODE_ENC: result_next = encrypt_block(head.data_block, keys_reg);
            MODE_DEC: result_next = decrypt_block(head.data_block, keys_reg);
            default:  result_next = head.data_block;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keys_reg  <= expand_key(KEY_RESET);
            valid_reg <= 1'b0;
        end
        else
        begin
            keys_reg  <= keys_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg       <= result_next;
            counter_used_reg <= head.counter_used;
        end
    end

endmodule

`default_nettype wire

// ===== sv/simplified_aes_ctr_cipher.sv =====
// Top level of the S-AES counter-mode cipher: front end, item queue, back end.
// Depends on saes_pkg, saes_front, saes_queue and saes_back.
//
// Input side is a queue: drive data_block with push high; the item is taken
// at a clock edge where full is low. Result side is a queue too: while empty
// is low, result_block and counter_used show the oldest result; pop high at
// an edge takes it.
// Each item gives one result. An accepted item is written into the queue, then
// into the output register, where empty falls; one item per cycle is sustained
// while pop drains the output register, set by the combinational back-end rounds.
// When pop stays low, the output register holds its result, the queue fills
// with QUEUE_DEPTH further items and then full rises.
// Configuration: cfg_write with cfg_index 0 loads the key (round keys are
// expanded on the write), 1 reloads the counter, 2 sets the mode. Write only
// while no items are in flight.
// Reset clears the queue and output register, sets the key to 0, the counter
// to 1200 and the mode to counter mode.
`default_nettype none

module simplified_aes_ctr_cipher
    import saes_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire logic [15:0]  data_block,
    output logic              empty,
    input  wire logic         pop,
    output logic [15:0]       result_block,
    output logic [15:0]       counter_used,
    input  wire logic         cfg_write,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);

    cfg_write_t cfg;
    item_t      front_item;
    item_t      queue_head;
    logic       front_push;
    logic       queue_full;
    logic       queue_empty;
    logic       back_pop;

    assign cfg.wen   = cfg_write;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;
    assign full      = queue_full;

    saes_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .push       (push),
        .data_block (data_block),
        .queue_full (queue_full),
        .queue_push (front_push),
        .queue_item (front_item)
    );

    saes_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (back_pop),
        .head      (queue_head),
        .empty     (queue_empty)
    );

    saes_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .head         (queue_head),
        .queue_empty  (queue_empty),
        .queue_pop    (back_pop),
        .empty        (empty),
        .pop          (pop),
        .result_block (result_block),
        .counter_used (counter_used)
    );

endmodule

`default_nettype wire
